>>> rtl/glsw_pkg.sv
// Shared types, codes and sizes for the grid line-of-sight walker.
package glsw_pkg;

  // Field widths fixed by the transaction format.
  localparam int COORD_W  = 6;
  localparam int STEP_W   = 7;
  localparam int ERR_W    = 8;
  localparam int OUTCOME_W = 2;

  // Default map size.
  localparam int MAP_WIDTH_DEF  = 64;
  localparam int MAP_HEIGHT_DEF = 64;

  // Command opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Layer select codes.
  localparam logic LAYER_BLOCKING = 1'b0;
  localparam logic LAYER_SHADOW   = 1'b1;

  // Query outcome codes.
  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_REACHED   = 2'd0,
    OUTCOME_BLOCKED   = 2'd1,
    OUTCOME_EXHAUSTED = 2'd2
  } outcome_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DONE
  } state_t;

  // Tile map write port.
  typedef struct packed {
    logic               en;
    logic               layer;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               value;
  } map_wr_t;

  // Tile map read port.
  typedef struct packed {
    logic               layer;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } map_rd_t;

  // Operands of one line step.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ERR_W-1:0]   err;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               sx_neg;
    logic               sy_neg;
  } step_in_t;

  // Result of one line step.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ERR_W-1:0]   err;
  } step_out_t;

endpackage

>>> rtl/glsw_if.sv
// Command and result channel interfaces of the grid line-of-sight walker.
interface glsw_cmd_if
  import glsw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               op;
  logic               layer;
  logic [COORD_W-1:0] tile_x;
  logic [COORD_W-1:0] tile_y;
  logic               tile_blocked;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic [STEP_W-1:0]  max_steps;

  modport source (
    output valid, op, layer, tile_x, tile_y, tile_blocked,
           start_x, start_y, end_x, end_y, max_steps,
    input  ready
  );
  modport sink (
    input  valid, op, layer, tile_x, tile_y, tile_blocked,
           start_x, start_y, end_x, end_y, max_steps,
    output ready
  );
endinterface

interface glsw_res_if
  import glsw_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 visible;
  logic [OUTCOME_W-1:0] outcome;

  modport source (output valid, visible, outcome, input ready);
  modport sink (input valid, visible, outcome, output ready);
endinterface

>>> rtl/glsw_map.sv
// Two one-bit tile map memories with a clearing pass after reset.
module glsw_map
  import glsw_pkg::*;
#(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  map_wr_t wr,
  input  map_rd_t rd,
  output logic    rd_value,
  output logic    busy
);

  // Only tiles reachable by a coordinate field need storage.
  localparam int COORD_SPAN = 1 << COORD_W;
  localparam int COLS  = (MAP_WIDTH  < COORD_SPAN) ? MAP_WIDTH  : COORD_SPAN;
  localparam int ROWS  = (MAP_HEIGHT < COORD_SPAN) ? MAP_HEIGHT : COORD_SPAN;
  localparam int COL_W = $clog2(COLS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic blk_mem [DEPTH];
  logic shd_mem [DEPTH];

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_in_map;
  logic              rd_in_map;
  logic              rd_blk;
  logic              rd_shd;
  logic              rd_layer_q;
  logic              rd_in_map_q;

  // Tiles beyond the configured map are dropped on write and read as clear.
  assign wr_in_map = (int'(wr.x) < MAP_WIDTH) && (int'(wr.y) < MAP_HEIGHT);
  assign rd_in_map = (int'(rd.x) < MAP_WIDTH) && (int'(rd.y) < MAP_HEIGHT);
  assign wr_addr   = {wr.y[ROW_W-1:0], wr.x[COL_W-1:0]};
  assign rd_addr   = {rd.y[ROW_W-1:0], rd.x[COL_W-1:0]};

  // Clearing pass: one entry of each layer per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Memory write port, shared by the clearing pass and tile writes.
  always_ff @(posedge clk) begin
    if (busy) begin
      blk_mem[clr_addr] <= 1'b0;
      shd_mem[clr_addr] <= 1'b0;
    end else if (wr.en && wr_in_map) begin
      if (wr.layer == LAYER_SHADOW) begin
        shd_mem[wr_addr] <= wr.value;
      end else begin
        blk_mem[wr_addr] <= wr.value;
      end
    end
  end

  // Registered read of both layers at one address.
  always_ff @(posedge clk) begin
    rd_blk      <= blk_mem[rd_addr];
    rd_shd      <= shd_mem[rd_addr];
    rd_layer_q  <= rd.layer;
    rd_in_map_q <= rd_in_map;
  end

  assign rd_value = rd_in_map_q && ((rd_layer_q == LAYER_SHADOW) ? rd_shd : rd_blk);

endmodule

>>> rtl/glsw_step.sv
// One Bresenham step: error-term compares, error update and coordinate move.
module glsw_step
  import glsw_pkg::*;
(
  input  step_in_t  si,
  output step_out_t so
);

  logic signed [ERR_W:0] e2;
  logic signed [ERR_W:0] dx_s;
  logic signed [ERR_W:0] dy_s;
  logic signed [ERR_W:0] err_s;
  logic signed [ERR_W:0] err_upd;
  logic                  move_x;
  logic                  move_y;

  assign e2    = $signed({si.err, 1'b0});
  assign dx_s  = $signed({(ERR_W + 1 - COORD_W)'(0), si.dx});
  assign dy_s  = $signed({(ERR_W + 1 - COORD_W)'(0), si.dy});
  assign err_s = $signed({si.err[ERR_W-1], si.err});

  // Decide the axes to advance on.
  assign move_x = e2 > -dy_s;
  assign move_y = e2 < dx_s;

  // Error update stays within the error register's range on any line in the map.
  always_comb begin
    err_upd = err_s;
    if (move_x) begin
      err_upd = err_upd - dy_s;
    end
    if (move_y) begin
      err_upd = err_upd + dx_s;
    end
  end
  assign so.err = err_upd[ERR_W-1:0];

  // Coordinate moves by one tile in the line's direction.
  always_comb begin
    so.x = si.x;
    so.y = si.y;
    if (move_x) begin
      so.x = si.sx_neg ? si.x - COORD_W'(1) : si.x + COORD_W'(1);
    end
    if (move_y) begin
      so.y = si.sy_neg ? si.y - COORD_W'(1) : si.y + COORD_W'(1);
    end
  end

endmodule

>>> rtl/grid_line_of_sight_walker_unit.sv
// Top level of the grid line-of-sight walker: sequencer, walk registers and result register.
//
//   Channel  Direction  Handshake      Carries
//   cmd      in         valid / ready  op, layer, tile write fields, query fields
//   res      out        valid / ready  visible, outcome (one per query, none per write)
//
// A write is accepted in the idle state. A query passes through setup and then, using the
// single map read and step unit, checks one tile per cycle (at most 64 on a 64 by 64 map).
// After reset a clearing pass over 2^(col bits + row bits) entries (4096 on a 64 by 64 map)
// runs before cmd.ready first rises. cmd.ready is high whenever the sequencer is idle.
// A finished walk moves into the res output register; while an earlier result still waits
// there, the walk holds in its done state and cmd.ready stays low until that result is taken.
module grid_line_of_sight_walker_unit
  import glsw_pkg::*;
#(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
  input logic      clk,
  input logic      rst,
  glsw_cmd_if.sink cmd,
  glsw_res_if.source res
);

  state_t state;
  state_t state_next;

  logic [COORD_W-1:0] walk_x;
  logic [COORD_W-1:0] walk_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic               sx_neg;
  logic               sy_neg;
  logic [ERR_W-1:0]   error_term;
  logic [STEP_W-1:0]  step_count;
  logic [STEP_W-1:0]  limit;
  logic               layer;
  outcome_t           outcome;
  logic               result_valid;
  outcome_t           result_outcome;

  logic      cmd_acc;
  logic      query_acc;
  logic      map_busy;
  logic      tile_hit;
  logic      at_end;
  logic      at_limit;
  logic      result_load;
  map_wr_t   map_wr;
  map_rd_t   map_rd;
  step_in_t  step_in;
  step_out_t step_out;

  assign cmd_acc     = cmd.valid && cmd.ready;
  assign query_acc   = cmd_acc && (cmd.op == OP_QUERY);
  assign at_end      = (walk_x == end_x) && (walk_y == end_y);
  assign at_limit    = step_count == limit;
  assign result_load = (state == ST_DONE) && (!result_valid || res.ready);

  glsw_map #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .wr       (map_wr),
    .rd       (map_rd),
    .rd_value (tile_hit),
    .busy     (map_busy)
  );

  assign step_in = '{x: walk_x, y: walk_y, err: error_term, dx: dx, dy: dy,
                     sx_neg: sx_neg, sy_neg: sy_neg};

  glsw_step u_step (
    .si (step_in),
    .so (step_out)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (!map_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (query_acc) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (tile_hit || at_end || at_limit) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (result_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Handshakes and map port control.
  always_comb begin
    cmd.ready    = 1'b0;
    map_wr.en    = 1'b0;
    map_wr.layer = cmd.layer;
    map_wr.x     = cmd.tile_x;
    map_wr.y     = cmd.tile_y;
    map_wr.value = cmd.tile_blocked;
    map_rd.layer = layer;
    map_rd.x     = walk_x;
    map_rd.y     = walk_y;
    unique case (state)
      ST_CLEAR: begin
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
        map_wr.en = cmd.valid && (cmd.op == OP_WRITE);
      end
      ST_SETUP: begin
      end
      ST_WALK: begin
        // Fetch the next tile while the current one is checked.
        map_rd.x = step_out.x;
        map_rd.y = step_out.y;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished walk moves here so the sequencer can take the next command.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (res.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result_outcome <= outcome;
    end
  end

  assign res.valid   = result_valid;
  assign res.outcome = result_outcome;
  assign res.visible = result_outcome == OUTCOME_REACHED;

  // Walk datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (query_acc) begin
          walk_x     <= cmd.start_x;
          walk_y     <= cmd.start_y;
          end_x      <= cmd.end_x;
          end_y      <= cmd.end_y;
          limit      <= cmd.max_steps;
          layer      <= cmd.layer;
          step_count <= '0;
          sx_neg     <= !(cmd.start_x < cmd.end_x);
          sy_neg     <= !(cmd.start_y < cmd.end_y);
          dx <= (cmd.end_x > cmd.start_x) ? cmd.end_x - cmd.start_x
                                          : cmd.start_x - cmd.end_x;
          dy <= (cmd.end_y > cmd.start_y) ? cmd.end_y - cmd.start_y
                                          : cmd.start_y - cmd.end_y;
        end
      end
      ST_SETUP: begin
        error_term <= ERR_W'($signed({2'b00, dx}) - $signed({2'b00, dy}));
      end
      ST_WALK: begin
        if (tile_hit) begin
          outcome <= OUTCOME_BLOCKED;
        end else if (at_end) begin
          outcome <= OUTCOME_REACHED;
        end else if (at_limit) begin
          outcome <= OUTCOME_EXHAUSTED;
        end else begin
          walk_x     <= step_out.x;
          walk_y     <= step_out.y;
          error_term <= step_out.err;
          step_count <= step_count + 1'b1;
        end
      end
      ST_CLEAR, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // A stalled result stays unchanged until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.outcome)))
    else $error("result changed while stalled");

  // An accepted query always enters setup.
  a_query_setup: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> (state == ST_SETUP))
    else $error("accepted query did not start a walk");

  // A walk on the grid ends within one check per column or row.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (step_count <= STEP_W'(1 << COORD_W)))
    else $error("walk step count out of range");

  // No result appears without a walk having finished just before.
  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> ($past(state) == ST_DONE))
    else $error("result raised without a finished walk");

endmodule
